// ===== hdl/led_frame_receiver_unit_assert.svh =====
// Assertion macros for the serial frame receiver checks.
// No dependencies; included by the checker file.
`ifndef LED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define LFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define LFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lfr_pkg.sv =====
// Shared constants, types and frame layout for the serial frame receiver.
// No dependencies; compiled first.
`default_nettype none

package lfr_pkg;

  localparam int FRAME_CAPACITY = 11;
  localparam int CHECKED_BYTES  = 7;

  // Write index runs 0..FRAME_CAPACITY inclusive
  localparam int IDX_W  = $clog2(FRAME_CAPACITY + 1);
  localparam int ADDR_W = $clog2(FRAME_CAPACITY);
  localparam int CHK_W  = $clog2(CHECKED_BYTES);
  // Wide enough for index+1 against a byte
  localparam int CMP_W  = 9;

  localparam logic [7:0]  END_MARK       = 8'hFF;
  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [15:0] CHECKSUM_RESET = 16'd2019;

  // Frame byte positions
  localparam int POS_LEN     = 0;
  localparam int POS_RING    = 1;
  localparam int POS_MASK_HI = 2;
  localparam int POS_MASK_LO = 3;
  localparam int POS_RED     = 4;
  localparam int POS_GREEN   = 5;
  localparam int POS_BLUE    = 6;
  localparam int POS_SUM_HI  = 7;
  localparam int POS_SUM_LO  = 8;
  localparam int POS_CRC     = 9;

  typedef logic [7:0] byte_t;
  typedef logic [FRAME_CAPACITY-1:0][7:0] frame_t;

  typedef struct packed {
    logic done;
    logic sum_ok;
    logic crc_ok;
  } chk_res_t;

endpackage

`default_nettype wire

// ===== hdl/lfr_if.sv =====
// Valid/ready channel interfaces: received bytes in, decoded ring commands out.
// Depends on lfr_pkg.
`default_nettype none

interface lfr_rx_if;
  import lfr_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfr_res_if;
  import lfr_pkg::*;
  logic        valid;
  logic        ready;
  byte_t       ring_number;
  logic [15:0] ring_mask;
  byte_t       red_level;
  byte_t       green_level;
  byte_t       blue_level;
  logic        crc_match;

  modport source (output valid, output ring_number, output ring_mask, output red_level,
                  output green_level, output blue_level, output crc_match, input ready);
  modport sink   (input valid, input ring_number, input ring_mask, input red_level,
                  input green_level, input blue_level, input crc_match, output ready);
endinterface

`default_nettype wire

// ===== hdl/lfr_frame_store.sv =====
// Frame store with saturating write index and end-of-frame detection.
// Depends on lfr_pkg.
`default_nettype none

module lfr_frame_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lfr_pkg::byte_t wr_byte,
  output logic          frame_end,
  output lfr_pkg::frame_t frame
);
  import lfr_pkg::*;

  logic [IDX_W-1:0] wr_index;
  logic [IDX_W-1:0] wr_index_next;
  logic             slot_free;
  byte_t            len_byte;

  assign slot_free = wr_index < IDX_W'(FRAME_CAPACITY);
  // Length byte as it stands after this word is written
  assign len_byte  = (wr_index == '0) ? wr_byte : frame[POS_LEN];
  assign frame_end = (wr_byte == END_MARK) &&
                     ((CMP_W'(wr_index) + CMP_W'(1)) >= CMP_W'(len_byte));

  always_comb begin
    if (frame_end) begin
      wr_index_next = '0;
    end else if (slot_free) begin
      wr_index_next = wr_index + IDX_W'(1);
    end else begin
      wr_index_next = wr_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame    <= '0;
      wr_index <= '0;
    end else if (wr_en) begin
      // drop words once the store is full
      if (slot_free) begin
        frame[wr_index[ADDR_W-1:0]] <= wr_byte;
      end
      wr_index <= wr_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfr_check_unit.sv =====
// Bit-serial check unit: walks the checked bytes for the XOR sum and CRC-8,
// then compares both against the received values. Depends on lfr_pkg.
`default_nettype none

module lfr_check_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       checksum_base,
  input  logic [15:0]       recv_sum,
  input  lfr_pkg::byte_t    crc_ref,
  output logic [lfr_pkg::CHK_W-1:0] rd_addr,
  input  lfr_pkg::byte_t    rd_data,
  output lfr_pkg::chk_res_t res
);
  import lfr_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_LOAD, U_SHIFT, U_DONE} ustate_t;

  ustate_t          state;
  logic [CHK_W-1:0] byte_cnt;
  logic [2:0]       bit_cnt;
  byte_t            crc;
  byte_t            acc;
  byte_t            shreg;
  byte_t            crc_next;
  logic             fb;
  logic [15:0]      calc_sum;

  // one reflected CRC step per cycle in the shift state
  assign fb       = crc[0] ^ shreg[0];
  assign crc_next = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);

  assign rd_addr    = byte_cnt;
  assign calc_sum   = checksum_base - {8'h00, acc};
  assign res.done   = (state == U_DONE);
  assign res.sum_ok = (calc_sum == recv_sum);
  assign res.crc_ok = (crc == crc_ref);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      unique case (state)
        U_IDLE: begin
          if (start) begin
            byte_cnt <= '0;
            crc      <= '0;
            acc      <= '0;
            state    <= U_LOAD;
          end
        end
        U_LOAD: begin
          shreg   <= rd_data;
          acc     <= acc ^ rd_data;
          bit_cnt <= '0;
          state   <= U_SHIFT;
        end
        U_SHIFT: begin
          crc     <= crc_next;
          shreg   <= {1'b0, shreg[7:1]};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (byte_cnt == CHK_W'(CHECKED_BYTES - 1)) begin
              state <= U_DONE;
            end else begin
              byte_cnt <= byte_cnt + CHK_W'(1);
              state    <= U_LOAD;
            end
          end
        end
        U_DONE: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_frame_receiver_unit.sv =====
// Channel  Dir  Payload                                                  Accepted when
// rx       in   rx_byte                                                  rx.valid & rx.ready
// res      out  ring_number ring_mask red/green/blue_level crc_match     res.valid & res.ready
// cfg      in   cfg_wr_data (checksum base)                              cfg_wr_en
//
// A word that does not end a frame leaves rx.ready high.
// A frame-ending word holds rx.ready low while the check unit loads each of
// the seven checked bytes, shifts it bit by bit through the CRC and then
// compares both checks. A frame with a matching checksum loads the output
// register, which holds while res.ready is low; a later matching frame that
// finds it still occupied keeps rx.ready low after its check until it drains.
// Synchronous reset clears the store and index and loads the checksum base with CHECKSUM_RESET.
// Depends on lfr_pkg, lfr_if, lfr_frame_store and lfr_check_unit.
`default_nettype none

module led_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  lfr_rx_if.sink      rx,
  lfr_res_if.source   res
);
  import lfr_pkg::*;

  typedef enum logic [1:0] {ST_RECV, ST_CHECK, ST_HOLD} state_t;

  state_t           state;
  logic [15:0]      checksum_base;
  logic             crc_hold;
  logic             rx_accept;
  logic             frame_end;
  frame_t           frame;
  chk_res_t         chk;
  logic [CHK_W-1:0] rd_addr;
  byte_t            rd_data;
  logic             out_free;
  logic             load_now;
  logic             load_crc;

  assign rx.ready  = (state == ST_RECV);
  assign rx_accept = rx.valid && rx.ready;
  assign rd_data   = frame[ADDR_W'(rd_addr)];
  assign out_free  = !res.valid || res.ready;
  assign load_now  = ((state == ST_CHECK) && chk.done && chk.sum_ok && out_free) ||
                     ((state == ST_HOLD) && out_free);
  assign load_crc  = (state == ST_HOLD) ? crc_hold : chk.crc_ok;

  lfr_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (rx_accept),
    .wr_byte   (rx.rx_byte),
    .frame_end (frame_end),
    .frame     (frame)
  );

  lfr_check_unit u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (rx_accept && frame_end),
    .checksum_base (checksum_base),
    .recv_sum      ({frame[POS_SUM_HI], frame[POS_SUM_LO]}),
    .crc_ref       (frame[POS_CRC]),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res           (chk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      res.valid     <= 1'b0;
      checksum_base <= CHECKSUM_RESET;
    end else begin
      if (cfg_wr_en) begin
        checksum_base <= cfg_wr_data;
      end

      if (load_now) begin
        res.valid       <= 1'b1;
        res.ring_number <= frame[POS_RING];
        res.ring_mask   <= {frame[POS_MASK_HI], frame[POS_MASK_LO]};
        res.red_level   <= frame[POS_RED];
        res.green_level <= frame[POS_GREEN];
        res.blue_level  <= frame[POS_BLUE];
        res.crc_match   <= load_crc;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end

      unique case (state)
        ST_RECV: begin
          if (rx_accept && frame_end) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (chk.done) begin
            if (!chk.sum_ok || out_free) begin
              state <= ST_RECV;
            end else begin
              // output still occupied: hold the CRC flag until it drains
              crc_hold <= chk.crc_ok;
              state    <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_RECV;
          end
        end
        default: begin
          state <= ST_RECV;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfr_checker.sv =====
// Port-level checks for the serial frame receiver, bound to the top level.
// Depends on lfr_pkg and led_frame_receiver_unit_assert.svh.
`default_nettype none
`include "led_frame_receiver_unit_assert.svh"

module lfr_checker (
  input logic           clk,
  input logic           rst,
  input logic           rx_valid,
  input logic           rx_ready,
  input lfr_pkg::byte_t rx_byte,
  input logic           res_valid,
  input logic           res_ready
);
  import lfr_pkg::*;

  // a word other than the end mark never stalls the input
  `LFR_ASSERT(a_plain_word_no_stall, clk, rst, rx_valid && rx_ready && (rx_byte != END_MARK) |=> rx_ready, "input stalled after a plain word")
  // the frame check keeps the input stalled once it has begun
  `LFR_ASSERT(a_check_not_single, clk, rst, $fell(rx_ready) |=> !rx_ready, "frame check too short")
  // a result appears only out of a frame check
  `LFR_ASSERT(a_result_from_check, clk, rst, $rose(res_valid) |-> $past(!rx_ready), "result without a frame check")
  `LFR_ASSERT(a_result_held, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `LFR_ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind led_frame_receiver_unit lfr_checker u_lfr_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx.valid),
  .rx_ready  (rx.ready),
  .rx_byte   (rx.rx_byte),
  .res_valid (res.valid),
  .res_ready (res.ready)
);

`default_nettype wire

// ===== tb/sv/led_frame_receiver_unit_tb.sv =====
// Testbench for led_frame_receiver_unit: byte stream in, decoded ring commands out.
// Predicts each command from its own frame store copy and checks field by field.
// Depends on lfr_pkg, lfr_if and the receiver RTL.
`timescale 1ns / 100ps

module led_frame_receiver_unit_tb;
  import lfr_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 3000;
  localparam int FRAME_BODY    = POS_CRC + 1;

  typedef byte_t img_t [FRAME_CAPACITY];

  typedef struct {
    byte_t       ring_number;
    logic [15:0] ring_mask;
    byte_t       red_level;
    byte_t       green_level;
    byte_t       blue_level;
    logic        crc_match;
  } ring_cmd_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  lfr_rx_if  rx_ch ();
  lfr_res_if res_ch ();

  led_frame_receiver_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_ch),
    .res         (res_ch)
  );

  // Local copy of the receiver state
  img_t             frame_img = '{default: 8'd0};
  logic [IDX_W-1:0] frame_idx = '0;
  logic [15:0]      sum_base  = CHECKSUM_RESET;

  ring_cmd_t ring_cmds [$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  bit        idle_on    = 1'b1;
  bit        hold_res   = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic byte_t xor_of(input img_t f);
    byte_t acc;
    acc = 8'd0;
    for (int i = 0; i < CHECKED_BYTES; i++) acc ^= f[i];
    return acc;
  endfunction

  function automatic byte_t crc_of(input img_t f);
    byte_t crc;
    byte_t v;
    crc = 8'd0;
    for (int i = 0; i < CHECKED_BYTES; i++) begin
      v = f[i];
      for (int k = 0; k < 8; k++) begin
        if (crc[0] ^ v[0]) crc = (crc >> 1) ^ CRC_POLY;
        else crc = crc >> 1;
        v = v >> 1;
      end
    end
    return crc;
  endfunction

  // Advance the local store by one word; queue a command when a frame passes its checksum
  function automatic void take_rx_byte(input byte_t b);
    ring_cmd_t   cmd;
    logic [15:0] calc;
    if (frame_idx < IDX_W'(FRAME_CAPACITY)) frame_img[frame_idx] = b;
    if (b == END_MARK && int'(frame_idx) + 1 >= int'(frame_img[POS_LEN])) begin
      frame_idx = '0;
      calc = sum_base - {8'd0, xor_of(frame_img)};
      if (calc == {frame_img[POS_SUM_HI], frame_img[POS_SUM_LO]}) begin
        cmd.ring_number = frame_img[POS_RING];
        cmd.ring_mask   = {frame_img[POS_MASK_HI], frame_img[POS_MASK_LO]};
        cmd.red_level   = frame_img[POS_RED];
        cmd.green_level = frame_img[POS_GREEN];
        cmd.blue_level  = frame_img[POS_BLUE];
        cmd.crc_match   = (crc_of(frame_img) == frame_img[POS_CRC]);
        ring_cmds.push_back(cmd);
      end
    end else if (frame_idx < IDX_W'(FRAME_CAPACITY)) begin
      frame_idx++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_byte(input byte_t b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    take_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic drop_rx_valid();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every command is out and the check unit has finished
  task automatic wait_block_idle();
    drop_rx_valid();
    while (ring_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(input logic [15:0] v);
    wait_block_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sum_base = v;
  endtask

  // Send 255s until the local index is back at the start of a frame
  task automatic align_to_frame();
    while (frame_idx != '0) send_byte(END_MARK);
  endtask

  // Build one frame against the current base; abandon it if an early 255 has ended it
  task automatic send_cmd_frame(input byte_t len, input byte_t ring, input logic [15:0] mask,
                                input byte_t red, input byte_t green, input byte_t blue,
                                input bit sum_ok, input bit crc_ok, input int extra);
    img_t        f;
    logic [15:0] sum;
    f = '{default: 8'd0};
    f[POS_LEN]     = len;
    f[POS_RING]    = ring;
    f[POS_MASK_HI] = mask[15:8];
    f[POS_MASK_LO] = mask[7:0];
    f[POS_RED]     = red;
    f[POS_GREEN]   = green;
    f[POS_BLUE]    = blue;
    sum = sum_base - {8'd0, xor_of(f)};
    if (!sum_ok) sum ^= 16'($urandom_range(1, 65535));
    f[POS_SUM_HI] = sum[15:8];
    f[POS_SUM_LO] = sum[7:0];
    f[POS_CRC]    = crc_of(f) ^ (crc_ok ? 8'd0 : 8'($urandom_range(1, 255)));
    align_to_frame();
    for (int i = 0; i < FRAME_BODY; i++) if (i == 0 || frame_idx != '0) send_byte(f[i]);
    repeat (extra) if (frame_idx != '0) send_byte(8'($urandom_range(0, 254)));
    if (frame_idx != '0) send_byte(END_MARK);
  endtask

  task automatic send_random_frame(input bit sum_ok);
    byte_t len;
    int    extra;
    len   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 12)) : 8'd11;
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0;
    send_cmd_frame(len, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), sum_ok, $urandom_range(0, 3) != 0, extra);
  endtask

  task automatic test_reset_base();
    send_cmd_frame(8'd11, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 0);
    send_cmd_frame(8'd10, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 0);
  endtask

  task automatic test_special_cases();
    // bad checksum: frame closes with no command
    send_cmd_frame(8'd11, 8'h5A, 16'hA5C3, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 0);
    // overlong frame: words past the store are dropped, index saturates
    send_cmd_frame(8'd11, 8'h3C, 16'h8001, 8'h80, 8'h7F, 8'h01, 1'b1, 1'b1, 4);
    // short length bytes let an early 255 close the frame on stale data
    align_to_frame();
    send_byte(8'd1);
    send_byte(END_MARK);
    send_byte(8'd0);
    send_byte(8'd9);
    send_byte(END_MARK);
    send_byte(8'd2);
    send_byte(END_MARK);
  endtask

  task automatic test_base_sweep();
    logic [15:0] bases [5];
    bases = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom), CHECKSUM_RESET};
    foreach (bases[k]) begin
      write_base(bases[k]);
      repeat (10) send_random_frame($urandom_range(0, 5) != 0);
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while frames keep coming, so the next frame end stalls rx
    hold_res = 1'b1;
    repeat (6) send_random_frame(1'b1);
    wait_block_idle();
    repeat (3) send_random_frame(1'b1);
  endtask

  task automatic test_random_traffic();
    int frames;
    int pick;
    frames = 0;
    while (bytes_sent < 1300) begin
      if (frames % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) send_random_frame(1'b1);
      else if (pick < 17) send_random_frame(1'b0);
      else repeat ($urandom_range(1, 12))
        send_byte(frame_idx == '0 ? 8'($urandom_range(0, 12)) : 8'($urandom));
      frames++;
    end
  endtask

  task automatic test_steady_tail();
    idle_on = 1'b0;
    repeat (12) send_random_frame(1'b1);
  endtask

  // A length byte no index can reach keeps any frame from ending until reset, so this runs last
  task automatic test_stuck_length();
    align_to_frame();
    send_byte(8'd200);
    repeat (12) send_byte(8'($urandom));
    repeat (3) send_byte(END_MARK);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 16'd0;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_base();
    test_special_cases();
    test_base_sweep();
    test_backpressure();
    test_random_traffic();
    test_steady_tail();
    test_stuck_length();
    drop_rx_valid();
    while (ring_cmds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : res_stall
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_res) begin
        stall_left = HOLD_CYCLES;
        hold_res   = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      res_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : result_check
    ring_cmd_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (ring_cmds.size() == 0) begin
        report_mismatch("command word with none expected");
      end else begin
        want = ring_cmds.pop_front();
        check_field("ring_number", 16'(res_ch.ring_number), 16'(want.ring_number));
        check_field("ring_mask", res_ch.ring_mask, want.ring_mask);
        check_field("red_level", 16'(res_ch.red_level), 16'(want.red_level));
        check_field("green_level", 16'(res_ch.green_level), 16'(want.green_level));
        check_field("blue_level", 16'(res_ch.blue_level), 16'(want.blue_level));
        check_field("crc_match", 16'(res_ch.crc_match), 16'(want.crc_match));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lfr_pkg.sv
hdl/lfr_if.sv
hdl/lfr_frame_store.sv
hdl/lfr_check_unit.sv
hdl/led_frame_receiver_unit.sv
hdl/lfr_checker.sv
tb/sv/led_frame_receiver_unit_tb.sv
